>>> rtl/core/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared sizes, command and status types of the maximal rectangle scanner.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_HEIGHT  = 1024;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int DEPTH_W   = $clog2(MAX_COLUMNS + 1);
  localparam int H_W       = $clog2(MAX_HEIGHT + 1);
  localparam int STK_W     = COL_W + H_W;
  localparam int CFG_W     = 7;
  localparam int RECT_W_W  = 7;
  localparam int RECT_H_W  = 11;
  localparam int ROW_RESET = 64;

  typedef struct packed {
    logic accept;
    logic rd_height;
    logic calc;
    logic rd_below;
    logic push;
    logic pop;
    logic done;
  } mrs_cmd_t;

  typedef struct packed {
    logic pop_needed;
    logic row_end;
    logic flushing;
    logic out_free;
  } mrs_status_t;

endpackage

>>> rtl/core/mrs_ram.sv
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mrs_ctrl.sv
// ----------------------------------------------------------------------------
// mrs_ctrl
// Sequencer: height read and update, stack pops, push and end of row flush.
// ----------------------------------------------------------------------------
module mrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrs_pkg::mrs_status_t status,
  output mrs_pkg::mrs_cmd_t    cmd
);

  import mrs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CALC  = 5'b00100,
    S_CHECK = 5'b01000,
    S_POP   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_height = 1'b1;
        state_next    = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.pop_needed) begin
          cmd.rd_below = 1'b1;
          state_next   = S_POP;
        end else if (!status.flushing) begin
          cmd.push = 1'b1;
          if (!status.row_end) begin
            cmd.done   = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (status.out_free) begin
          cmd.pop    = 1'b1;
          state_next = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/mrs_datapath.sv
// ----------------------------------------------------------------------------
// mrs_datapath
// Column heights, position stack, row position and result register.
// ----------------------------------------------------------------------------
module mrs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  mrs_pkg::mrs_cmd_t               cmd,
  output mrs_pkg::mrs_status_t            status,
  input  logic                            cell_open,
  input  logic                            map_start,
  input  logic                            cfg_write,
  input  logic [mrs_pkg::CFG_W-1:0]       cfg_row_length,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mrs_pkg::RECT_W_W-1:0]    rect_width,
  output logic [mrs_pkg::RECT_H_W-1:0]    rect_height,
  output logic                            last_of_run
);

  import mrs_pkg::*;

  logic [CFG_W-1:0]       row_len;
  logic [CFG_W-1:0]       len;
  logic [COL_W-1:0]       col;
  logic                   first_row;
  logic                   flushing;
  logic [DEPTH_W-1:0]     depth;
  logic                   cell_q;
  logic [H_W-1:0]         h_cur;
  logic [H_W-1:0]         top_h;
  logic [MAX_COLUMNS-1:0] hvalid;

  logic [H_W-1:0]         h_rd;
  logic [H_W-1:0]         h_old;
  logic [H_W-1:0]         h_next;
  logic [STK_W-1:0]       s_rd;
  logic [COL_W-1:0]       below_pos;
  logic [H_W-1:0]         below_h;
  logic [DEPTH_W-1:0]     pos;
  logic [DEPTH_W-1:0]     width;
  logic                   row_end;
  logic                   push_ok;
  logic                   pop_last;

  always_comb begin
    if (row_len == '0) begin
      len = CFG_W'(1);
    end else if (CFG_W'(MAX_COLUMNS) < row_len) begin
      len = CFG_W'(MAX_COLUMNS);
    end else begin
      len = row_len;
    end
  end

  assign row_end = (CFG_W'(col) + CFG_W'(1)) >= len;

  assign h_old = hvalid[col] ? h_rd : '0;

  always_comb begin
    if (!cell_q) begin
      h_next = '0;
    end else if (first_row) begin
      h_next = H_W'(1);
    end else if (h_old < H_W'(MAX_HEIGHT)) begin
      h_next = h_old + H_W'(1);
    end else begin
      h_next = H_W'(MAX_HEIGHT);
    end
  end

  mrs_ram #(
    .WIDTH (H_W),
    .DEPTH (MAX_COLUMNS)
  ) u_height_ram (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (col),
    .wdata (h_next),
    .re    (cmd.rd_height),
    .raddr (col),
    .rdata (h_rd)
  );

  assign push_ok = cmd.push && (depth < DEPTH_W'(MAX_COLUMNS));

  mrs_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_COLUMNS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (depth[COL_W-1:0]),
    .wdata ({col, h_cur}),
    .re    (cmd.rd_below),
    .raddr (depth[COL_W-1:0] - COL_W'(2)),
    .rdata (s_rd)
  );

  assign below_pos = s_rd[STK_W-1:H_W];
  assign below_h   = s_rd[H_W-1:0];

  assign pos   = flushing ? (DEPTH_W'(col) + DEPTH_W'(1)) : DEPTH_W'(col);
  assign width = (depth == DEPTH_W'(1)) ? pos
               : (pos - DEPTH_W'(below_pos) - DEPTH_W'(1));

  assign pop_last = flushing ? (depth == DEPTH_W'(1))
                  : (!((depth > DEPTH_W'(1)) && (below_h > h_cur)) && !row_end);

  assign status.pop_needed = (depth != '0) && (flushing || (top_h > h_cur));
  assign status.row_end    = row_end;
  assign status.flushing   = flushing;
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len   <= CFG_W'(ROW_RESET);
      col       <= '0;
      first_row <= 1'b1;
      flushing  <= 1'b0;
      depth     <= '0;
      hvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        row_len <= cfg_row_length;
      end
      if (cmd.accept && map_start) begin
        hvalid    <= '0;
        depth     <= '0;
        col       <= '0;
        first_row <= 1'b1;
      end
      if (cmd.calc) begin
        hvalid[col] <= 1'b1;
      end
      if (push_ok) begin
        depth <= depth + DEPTH_W'(1);
      end
      if (cmd.push && row_end) begin
        flushing <= 1'b1;
      end
      if (cmd.pop) begin
        depth     <= depth - DEPTH_W'(1);
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.done) begin
        flushing <= 1'b0;
        if (row_end) begin
          col       <= '0;
          first_row <= 1'b0;
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cell_q <= cell_open;
    end
    if (cmd.calc) begin
      h_cur <= h_next;
    end
    if (push_ok) begin
      top_h <= h_cur;
    end
    if (cmd.pop) begin
      top_h       <= below_h;
      rect_width  <= RECT_W_W'(width);
      rect_height <= RECT_H_W'(top_h);
      last_of_run <= pop_last;
    end
  end

endmodule

>>> rtl/core/maximal_rectangle_scan_core.sv
// ----------------------------------------------------------------------------
// maximal_rectangle_scan_core
// Histogram stack scanner that emits candidate rectangles of an occupancy map.
//
// Input channel (in_valid / in_stall) takes one map cell per transaction,
// cell_open and map_start, in row order. Output channel (out_valid / out_stall)
// gives rect_width, rect_height and last_of_run per transaction; a cell may
// give none or up to one rectangle per column of the row. The user must write
// row_length over the cfg_valid / cfg_ready channel while idle; not enforced.
//
// An item is accepted, its column height is read and then updated, and the
// stack is checked; every rectangle it pops adds a stack read and a pop, and
// the last cell of a row adds a push before the end of row flush. The
// height memory and stack memory each have one registered read port, and the
// pop loop reads the stack entry below the top once per rectangle.
//
// Reset clears the column heights, the stack, the row position and sets
// row_length to 64; no clearing pass is needed. When the receiver stalls,
// the result register holds and the pop loop waits, so in_stall stays high
// until the item is done. A new cell is taken while a result waits.
// ----------------------------------------------------------------------------
module maximal_rectangle_scan_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cell_open,
  input  logic                          map_start,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrs_pkg::CFG_W-1:0]     row_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mrs_pkg::RECT_W_W-1:0]  rect_width,
  output logic [mrs_pkg::RECT_H_W-1:0]  rect_height,
  output logic                          last_of_run
);

  import mrs_pkg::*;

  mrs_cmd_t    cmd;
  mrs_status_t status;

  assign cfg_ready = 1'b1;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mrs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cell_open      (cell_open),
    .map_start      (map_start),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_row_length (row_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .rect_width     (rect_width),
    .rect_height    (rect_height),
    .last_of_run    (last_of_run)
  );

endmodule

>>> tb/tb_maximal_rectangle_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_maximal_rectangle_scan_core
// Self-checking bench for the histogram stack rectangle scanner.
//
// Map cells are queued by the stimulus process and sent by a clocked driver
// with random gaps. Each sent cell updates a bench-side model of the column
// heights and the position stack, which queues the rectangles the core should
// give. A clocked monitor stalls the result side at random and checks each
// result against the oldest queued rectangle. The row length is rewritten
// between phases, with the core idle, over the whole range including
// zero, one, 64, values above 64 and a shortening in the middle of a row.
// ----------------------------------------------------------------------------
module tb_maximal_rectangle_scan_core;
  import mrs_pkg::*;

  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic is_open;
    logic new_map;
  } cell_t;

  typedef struct {
    logic [RECT_W_W-1:0] width;
    logic [RECT_H_W-1:0] height;
    logic                last;
  } rect_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cell_open = 1'b0;
  logic                map_start = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    row_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RECT_W_W-1:0] rect_width;
  logic [RECT_H_W-1:0] rect_height;
  logic                last_of_run;

  maximal_rectangle_scan_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cell_open   (cell_open),
    .map_start   (map_start),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .row_length  (row_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .last_of_run (last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bench copy of the scanner state
  logic [H_W-1:0]   col_height [MAX_COLUMNS];
  logic [COL_W-1:0] bar_pos [MAX_COLUMNS];
  int               bar_cnt = 0;
  int               next_col = 0;
  bit               first_row = 1'b1;
  logic [CFG_W-1:0] cfg_row_len = 7'd64;

  cell_t cells_to_send[$];
  rect_t rects_due[$];
  cell_t next_cell;
  rect_t due_rect;
  int    unsent = 0;
  int    queued = 0;
  int    errors = 0;
  int    send_gap = 0;
  int    send_calm = 0;
  int    stall_left = 0;
  int    stall_calm = 0;

  initial begin
    foreach (col_height[i]) col_height[i] = '0;
    foreach (bar_pos[i]) bar_pos[i] = '0;
  end

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void pop_bar(int pos);
    rect_t r;
    int    top;
    int    w;
    top = int'(bar_pos[bar_cnt-1]);
    r.height = col_height[top];
    bar_cnt--;
    if (bar_cnt == 0) w = pos;
    else w = pos - int'(bar_pos[bar_cnt-1]) - 1;
    r.width = w[RECT_W_W-1:0];
    r.last = 1'b0;
    rects_due = {rects_due, r};
  endfunction

  function automatic void predict_rects(logic is_open, logic new_map);
    int eff;
    int k;
    int h;
    int n0;
    n0 = rects_due.size();
    if (new_map) begin
      foreach (col_height[i]) col_height[i] = '0;
      bar_cnt = 0;
      next_col = 0;
      first_row = 1'b1;
    end
    if (cfg_row_len == 0) eff = 1;
    else if (cfg_row_len > MAX_COLUMNS) eff = MAX_COLUMNS;
    else eff = int'(cfg_row_len);
    k = next_col;
    if (first_row) h = int'(is_open);
    else if (is_open)
      h = (col_height[k] < MAX_HEIGHT) ? int'(col_height[k]) + 1 : MAX_HEIGHT;
    else h = 0;
    col_height[k] = h[H_W-1:0];
    while (bar_cnt > 0 && col_height[bar_pos[bar_cnt-1]] > h) pop_bar(k);
    if (bar_cnt < MAX_COLUMNS) begin
      bar_pos[bar_cnt] = k[COL_W-1:0];
      bar_cnt++;
    end
    if (k + 1 >= eff) begin
      while (bar_cnt > 0) pop_bar(k + 1);
      next_col = 0;
      first_row = 1'b0;
    end else begin
      next_col = k + 1;
    end
    if (rects_due.size() > n0) rects_due[rects_due.size()-1].last = 1'b1;
  endfunction

  task automatic report(string what);
    errors++;
    if (errors <= 50) $display("%0t mismatch: %s", $time, what);
  endtask

  // cell driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rects(cell_open, map_start);
        unsent--;
        send_gap = pick_gap(send_calm);
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cells_to_send.size() > 0) begin
        next_cell = cells_to_send.pop_front();
        cell_open <= next_cell.is_open;
        map_start <= next_cell.new_map;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // rectangle monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rects_due.size() == 0) begin
          report($sformatf("unexpected rectangle w=%0d h=%0d", rect_width, rect_height));
        end else begin
          due_rect = rects_due.pop_front();
          if (rect_width !== due_rect.width)
            report($sformatf("width got %0d want %0d", rect_width, due_rect.width));
          if (rect_height !== due_rect.height)
            report($sformatf("height got %0d want %0d", rect_height, due_rect.height));
          if (last_of_run !== due_rect.last)
            report($sformatf("last_of_run got %0b want %0b", last_of_run, due_rect.last));
        end
        stall_left = pick_gap(stall_calm);
      end else if (!out_valid && stall_left == 0 && $urandom_range(0, 15) == 0) begin
        stall_left = pick_gap(stall_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_cell(logic is_open, logic new_map);
    cell_t c;
    c.is_open = is_open;
    c.new_map = new_map;
    cells_to_send = {cells_to_send, c};
    unsent++;
    queued++;
  endtask

  task automatic push_pattern(int n, logic [63:0] bits, logic new_map);
    for (int i = 0; i < n; i++) push_cell(bits[i], new_map && i == 0);
  endtask

  task automatic wait_idle();
    while (unsent != 0 || rects_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_row_length(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_valid  <= 1'b1;
    row_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_row_len = v;
  endtask

  initial begin
    int len;
    int eff;
    int n;
    int dens;
    int phase;
    bit fresh;
    int lens [5];

    lens = '{0, 1, 5, 127, 64};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // short directed maps
    set_row_length(7'd4);
    push_pattern(4, 64'b1011, 1'b1);
    push_pattern(4, 64'b1111, 1'b0);
    push_pattern(4, 64'b0110, 1'b0);
    push_pattern(2, 64'b11, 1'b0);
    push_pattern(4, 64'b1010, 1'b1);
    set_row_length(7'd8);
    push_pattern(6, 64'b111101, 1'b1);
    set_row_length(7'd3);
    push_pattern(3, 64'b011, 1'b0);

    phase = 0;
    while (queued < 160) begin
      if (phase < 5) len = lens[phase];
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 127);
      else len = $urandom_range(2, 12);
      set_row_length(len[CFG_W-1:0]);
      if (len == 0) eff = 1;
      else if (len > MAX_COLUMNS) eff = MAX_COLUMNS;
      else eff = len;
      if (eff >= 32) n = eff + $urandom_range(0, 8);
      else n = eff * $urandom_range(2, 5) + $urandom_range(0, eff / 2);
      case ($urandom_range(0, 4))
        0: dens = 100;
        1: dens = 85;
        2: dens = 50;
        3: dens = 15;
        default: dens = 0;
      endcase
      fresh = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n; i++) begin
        if (phase == 3 && i == n / 2) wait_idle();
        push_cell($urandom_range(0, 99) < dens,
                  (i == 0 && fresh) || $urandom_range(0, 49) == 0);
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
